// File: hdl/pkrh_pkg.sv
`default_nettype none
package pkrh_pkg;

   // Default sizes
   localparam int DEF_WINDOW_DEPTH = 64;
   localparam int DEF_KEY_COUNT    = 64;
   localparam int DEF_RECORD_WIDTH = 64;

   // Fixed field widths on the ports
   localparam int REQ_KEY_W  = 12;
   localparam int REC_PORT_W = 64;
   localparam int WANT_W     = 7;
   localparam int AGE_W      = 6;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Request mode codes
   localparam logic [1:0] MODE_APPEND = 2'd0;
   localparam logic [1:0] MODE_READ   = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   // Classified command kinds
   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_READ   = 2'd1,
      OP_EMPTY  = 2'd2,
      OP_CLEAR  = 2'd3
   } pkrh_op_type;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      ST_SWEEP  = 2'd0,
      ST_IDLE   = 2'd1,
      ST_EXEC   = 2'd2,
      ST_STREAM = 2'd3
   } pkrh_state_type;

   typedef struct packed {
      logic [1:0]            mode;
      logic [REQ_KEY_W-1:0]  key_index;
      logic [REC_PORT_W-1:0] record_in;
      logic [WANT_W-1:0]     max_count;
   } pkrh_req_type;

   typedef struct packed {
      logic [REC_PORT_W-1:0] record_out;
      logic [AGE_W-1:0]      age;
      logic                  has_data;
      logic                  last;
   } pkrh_rsp_type;

   // Queue status
   typedef struct packed {
      logic full;
      logic empty;
   } pkrh_q_stat_type;

   // Back-end status
   typedef struct packed {
      logic sweeping;
      logic init;
   } pkrh_back_stat_type;

endpackage
`default_nettype wire

// File: hdl/per_key_recent_history_ring.sv
`default_nettype none
// Per-key history ring. Each of KEY_COUNT keys keeps its WINDOW_DEPTH most
// recent records. Items are taken when start is high and busy is low and,
// unless ignored, go into a two-entry command queue; a back-end sequencer then
// works them off one at a time: an append does a head/fill lookup, then a
// write; a read does the lookup, then one record memory read per cycle for
// n records (results on consecutive cycles, newest first, age counting up);
// an empty read answers from the queue or after the lookup; a clear sweeps
// the head/fill memory. After reset, busy stays high while that memory is
// swept. Results appear for one cycle with rsp_valid and cannot be stalled.
// busy is high while the queue is full or the reset sweep runs.
module per_key_recent_history_ring
   import pkrh_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
   parameter int KEY_COUNT    = DEF_KEY_COUNT,
   parameter int RECORD_WIDTH = DEF_RECORD_WIDTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire pkrh_req_type req_item,
   output logic              busy,
   output logic              rsp_valid,
   output pkrh_rsp_type      rsp_item
);

   localparam int KW    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int CMD_W = 2 + KW + RECORD_WIDTH + WANT_W;

   logic                    accept;
   logic                    q_push;
   logic                    q_pop;
   pkrh_op_type             f_op;
   logic [KW-1:0]           f_key;
   logic [RECORD_WIDTH-1:0] f_rec;
   logic [WANT_W-1:0]       f_want;
   logic [CMD_W-1:0]        q_in;
   logic [CMD_W-1:0]        q_out;
   pkrh_q_stat_type         q_stat;
   pkrh_back_stat_type      b_stat;

   assign busy   = q_stat.full || b_stat.init;
   assign accept = start && !busy;
   assign q_in   = {f_op, f_key, f_rec, f_want};

   pkrh_front #(
      .KEY_COUNT    (KEY_COUNT),
      .RECORD_WIDTH (RECORD_WIDTH)
   ) u_front (
      .accept (accept),
      .req    (req_item),
      .push   (q_push),
      .op     (f_op),
      .key    (f_key),
      .rec    (f_rec),
      .want   (f_want)
   );

   pkrh_queue #(
      .WIDTH (CMD_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .stat      (q_stat)
   );

   pkrh_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .KEY_COUNT    (KEY_COUNT),
      .RECORD_WIDTH (RECORD_WIDTH),
      .CMD_W        (CMD_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (q_out),
      .q_stat    (q_stat),
      .pop       (q_pop),
      .stat      (b_stat),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_item)
   );

`ifndef SYNTHESIS
   // Queue never written while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("command queue overflow");

   // Empty answers always close the run
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.has_data |-> rsp_item.last)
      else $error("empty result without last");

   // A read run is unbroken and ages count up by one
   a_run_contig: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last |=>
         rsp_valid && rsp_item.has_data && rsp_item.age == $past(rsp_item.age) + 6'd1)
      else $error("read run broken");

   // Reset sweep holds off all items
   a_sweep_busy: assert property (@(posedge clock) disable iff (reset)
      b_stat.init |-> busy && !rsp_valid)
      else $error("item accepted during reset sweep");

   // No result goes out while the head/fill memory is swept
   a_sweep_quiet: assert property (@(posedge clock) disable iff (reset)
      b_stat.sweeping |-> !rsp_valid)
      else $error("result during sweep");
`endif

endmodule
`default_nettype wire

// File: hdl/pkrh_front.sv
`default_nettype none
module pkrh_front
   import pkrh_pkg::*;
#(
   parameter int KEY_COUNT    = DEF_KEY_COUNT,
   parameter int RECORD_WIDTH = DEF_RECORD_WIDTH
) (
   input  wire logic                                accept,
   input  wire pkrh_req_type                        req,
   output logic                                     push,
   output pkrh_op_type                              op,
   output logic [((KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1)-1:0] key,
   output logic [RECORD_WIDTH-1:0]                  rec,
   output logic [WANT_W-1:0]                        want
);

   localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

   logic key_ok;

   assign key_ok = req.key_index < REQ_KEY_W'(KEY_COUNT);
   assign key    = req.key_index[KW-1:0];
   assign rec    = req.record_in[RECORD_WIDTH-1:0];
   assign want   = req.max_count;

   // Classify the item; ignored items are not queued
   always_comb begin
      push = 1'b0;
      op   = OP_EMPTY;
      unique case (req.mode)
         MODE_APPEND: begin
            op   = OP_APPEND;
            push = accept && key_ok;
         end
         MODE_READ: begin
            op   = (key_ok && (req.max_count != '0)) ? OP_READ : OP_EMPTY;
            push = accept;
         end
         MODE_CLEAR: begin
            op   = OP_CLEAR;
            push = accept;
         end
         default: begin
            op   = OP_EMPTY;
            push = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: hdl/pkrh_queue.sv
`default_nettype none
module pkrh_queue
   import pkrh_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output pkrh_q_stat_type       stat
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [AW-1:0]    wr_ff, wr_in;
   logic [AW-1:0]    rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   assign stat.full  = cnt_ff == CW'(QUEUE_DEPTH);
   assign stat.empty = cnt_ff == '0;
   assign pop_data   = slot_ff[rd_ff];

   // Pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: hdl/pkrh_back.sv
`default_nettype none
module pkrh_back
   import pkrh_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
   parameter int KEY_COUNT    = DEF_KEY_COUNT,
   parameter int RECORD_WIDTH = DEF_RECORD_WIDTH,
   parameter int CMD_W        = 2 + ((KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1)
                                  + RECORD_WIDTH + WANT_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CMD_W-1:0] cmd,
   input  wire pkrh_q_stat_type  q_stat,
   output logic                  pop,
   output pkrh_back_stat_type    stat,
   output logic                  rsp_valid,
   output pkrh_rsp_type          rsp
);

   localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int PW = $clog2(WINDOW_DEPTH);
   localparam int FW = $clog2(WINDOW_DEPTH + 1);
   localparam int MW = PW + FW;
   localparam int REC_DEPTH = KEY_COUNT << PW;

   // Incoming command fields
   pkrh_op_type             q_op;
   logic [KW-1:0]           q_key;
   logic [RECORD_WIDTH-1:0] q_rec;
   logic [WANT_W-1:0]       q_want;

   // Latched command
   pkrh_op_type             op_ff, op_in;
   logic [KW-1:0]           key_ff, key_in;
   logic [RECORD_WIDTH-1:0] rec_ff, rec_in;
   logic [WANT_W-1:0]       want_ff, want_in;

   pkrh_state_type st_ff, st_in;
   logic [KW-1:0]  sweep_ff, sweep_in;
   logic           init_ff, init_in;
   logic [PW-1:0]  pos_ff, pos_in;
   logic [FW-1:0]  left_ff, left_in;
   logic [PW-1:0]  age_ff, age_in;

   // Per-key head and fill memory
   logic [MW-1:0] meta_mem [KEY_COUNT];
   logic [MW-1:0] meta_rd_ff;
   logic [KW-1:0] meta_raddr;
   logic [KW-1:0] meta_waddr;
   logic [MW-1:0] meta_wdata;
   logic          meta_we;
   logic [PW-1:0] m_head;
   logic [FW-1:0] m_fill;

   // Record memory, addressed {key, slot}
   logic [RECORD_WIDTH-1:0] rec_mem [REC_DEPTH];
   logic [RECORD_WIDTH-1:0] rec_rd_ff;
   logic                    rec_we;
   logic [KW+PW-1:0]        rec_waddr;
   logic [KW+PW-1:0]        rec_raddr;
   logic                    rd_issue;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              has_ff, has_in;
   logic              last_ff, last_in;
   logic [PW-1:0]     ageo_ff, ageo_in;

   assign q_op   = pkrh_op_type'(cmd[CMD_W-1 -: 2]);
   assign q_key  = cmd[CMD_W-3 -: KW];
   assign q_rec  = cmd[WANT_W +: RECORD_WIDTH];
   assign q_want = cmd[WANT_W-1:0];

   assign m_head = meta_rd_ff[MW-1 -: PW];
   assign m_fill = meta_rd_ff[FW-1:0];

   assign stat.sweeping = st_ff == ST_SWEEP;
   assign stat.init     = init_ff;

   // Sequencer: next state and memory controls
   always_comb begin
      st_in        = st_ff;
      sweep_in     = sweep_ff;
      init_in      = init_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      rec_in       = rec_ff;
      want_in      = want_ff;
      pos_in       = pos_ff;
      left_in      = left_ff;
      age_in       = age_ff;
      pop          = 1'b0;
      meta_raddr   = q_key;
      meta_we      = 1'b0;
      meta_waddr   = key_ff;
      meta_wdata   = '0;
      rec_we       = 1'b0;
      rec_waddr    = {key_ff, m_head};
      rec_raddr    = {key_ff, pos_ff};
      rd_issue     = 1'b0;
      rsp_valid_in = 1'b0;
      has_in       = has_ff;
      last_in      = last_ff;
      ageo_in      = ageo_ff;

      unique case (st_ff)
         ST_SWEEP: begin
            meta_we    = 1'b1;
            meta_waddr = sweep_ff;
            meta_wdata = '0;
            if (sweep_ff == KW'(KEY_COUNT - 1)) begin
               st_in   = ST_IDLE;
               init_in = 1'b0;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (!q_stat.empty) begin
               pop     = 1'b1;
               op_in   = q_op;
               key_in  = q_key;
               rec_in  = q_rec;
               want_in = q_want;
               unique case (q_op)
                  OP_CLEAR: begin
                     st_in    = ST_SWEEP;
                     sweep_in = '0;
                  end
                  OP_EMPTY: begin
                     rsp_valid_in = 1'b1;
                     has_in       = 1'b0;
                     last_in      = 1'b1;
                     ageo_in      = '0;
                  end
                  default: begin
                     st_in = ST_EXEC;
                  end
               endcase
            end
         end
         ST_EXEC: begin
            st_in = ST_IDLE;
            if (op_ff == OP_APPEND) begin
               rec_we     = 1'b1;
               meta_we    = 1'b1;
               meta_wdata[MW-1 -: PW] =
                  (m_head == PW'(WINDOW_DEPTH - 1)) ? '0 : m_head + 1'b1;
               meta_wdata[FW-1:0] =
                  (m_fill == FW'(WINDOW_DEPTH)) ? m_fill : m_fill + 1'b1;
            end else if (m_fill == '0) begin
               rsp_valid_in = 1'b1;
               has_in       = 1'b0;
               last_in      = 1'b1;
               ageo_in      = '0;
            end else begin
               // Start the newest-first walk
               st_in   = ST_STREAM;
               pos_in  = (m_head == '0) ? PW'(WINDOW_DEPTH - 1) : m_head - 1'b1;
               left_in = (want_ff < WANT_W'(m_fill)) ? FW'(want_ff) : m_fill;
               age_in  = '0;
            end
         end
         ST_STREAM: begin
            // One record read per cycle
            rd_issue     = 1'b1;
            rsp_valid_in = 1'b1;
            has_in       = 1'b1;
            last_in      = left_ff == FW'(1);
            ageo_in      = age_ff;
            left_in      = left_ff - 1'b1;
            age_in       = age_ff + 1'b1;
            pos_in       = (pos_ff == '0) ? PW'(WINDOW_DEPTH - 1) : pos_ff - 1'b1;
            if (left_ff == FW'(1)) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_SWEEP;
         sweep_ff     <= '0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         sweep_ff     <= sweep_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      key_ff  <= key_in;
      rec_ff  <= rec_in;
      want_ff <= want_in;
      pos_ff  <= pos_in;
      left_ff <= left_in;
      age_ff  <= age_in;
      has_ff  <= has_in;
      last_ff <= last_in;
      ageo_ff <= ageo_in;
   end

   // Meta memory
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_rd_ff <= meta_mem[meta_raddr];
   end

   // Record memory
   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[rec_waddr] <= rec_ff;
      end
      if (rd_issue) begin
         rec_rd_ff <= rec_mem[rec_raddr];
      end
   end

   // Result ports
   assign rsp_valid      = rsp_valid_ff;
   assign rsp.record_out = has_ff ? REC_PORT_W'(rec_rd_ff) : '0;
   assign rsp.age        = AGE_W'(ageo_ff);
   assign rsp.has_data   = has_ff;
   assign rsp.last       = last_ff;

endmodule
`default_nettype wire

// File: sim/testbench.sv
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pkrh_pkg::*;

   localparam int DEPTH = DEF_WINDOW_DEPTH;
   localparam int KEYS  = DEF_KEY_COUNT;
   // mode code the block has no use for
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   pkrh_req_type req_item = '0;
   logic         busy;
   logic         rsp_valid;
   pkrh_rsp_type rsp_item;

   per_key_recent_history_ring uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // items waiting to go out, and records the rings should give back
   pkrh_req_type req_backlog[$];
   pkrh_rsp_type due_records[$];

   // shadow copy of the rings
   logic [AGE_W-1:0]      ring_head [KEYS];
   logic [WANT_W-1:0]     ring_fill [KEYS];
   logic [REC_PORT_W-1:0] ring_data [KEYS][DEPTH];

   int unsigned send_idle_pct = 0;
   logic        took_item = 1'b0;
   int          fail_count = 0;
   int          n_items = 0;
   int          n_appends = 0;
   int          n_reads = 0;
   int          n_clears = 0;
   int          n_records = 0;

   task automatic report_mismatch(input string what);
      $display("%0t: MISMATCH %s", $realtime, what);
      fail_count++;
   endtask

   // work out the records one item produces and update the shadow rings
   task automatic predict_ring_op(input pkrh_req_type it);
      int unsigned   k;
      int unsigned   n;
      int unsigned   pos;
      pkrh_rsp_type  r;
      k = it.key_index;
      case (it.mode)
         MODE_APPEND: begin
            n_appends++;
            if (k < KEYS) begin
               ring_data[k][ring_head[k]] = it.record_in;
               ring_head[k] = AGE_W'((int'(ring_head[k]) + 1) % DEPTH);
               if (ring_fill[k] < DEPTH) ring_fill[k] = ring_fill[k] + 1'b1;
            end
         end
         MODE_READ: begin
            n_reads++;
            if (k >= KEYS || it.max_count == 0 || ring_fill[k] == 0) begin
               r = '0;
               r.last = 1'b1;
               due_records.push_back(r);
            end else begin
               n = (it.max_count < ring_fill[k]) ? it.max_count : ring_fill[k];
               for (int unsigned i = 0; i < n; i++) begin
                  pos = (ring_head[k] + 2 * DEPTH - 1 - i) % DEPTH;
                  r.record_out = ring_data[k][pos];
                  r.age        = AGE_W'(i);
                  r.has_data   = 1'b1;
                  r.last       = (i + 1 == n);
                  due_records.push_back(r);
               end
            end
         end
         MODE_CLEAR: begin
            n_clears++;
            for (int i = 0; i < KEYS; i++) begin
               ring_head[i] = '0;
               ring_fill[i] = '0;
            end
         end
         default: ;
      endcase
   endtask

   // driver: next item goes out on the falling edge once the last one was taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took_item) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            start    <= 1'b1;
            req_item <= req_backlog.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: note accepted items and check every result record
   always @(posedge clock) begin
      pkrh_rsp_type want;
      if (reset) begin
         took_item <= 1'b0;
      end else begin
         if (rsp_valid) begin
            n_records++;
            if (due_records.size() == 0) begin
               report_mismatch("result record with nothing expected");
            end else begin
               want = due_records.pop_front();
               if (rsp_item.record_out !== want.record_out)
                  report_mismatch($sformatf("record_out %h, expected %h",
                                            rsp_item.record_out, want.record_out));
               if (rsp_item.age !== want.age)
                  report_mismatch($sformatf("age %0d, expected %0d",
                                            rsp_item.age, want.age));
               if (rsp_item.has_data !== want.has_data)
                  report_mismatch($sformatf("has_data %b, expected %b",
                                            rsp_item.has_data, want.has_data));
               if (rsp_item.last !== want.last)
                  report_mismatch($sformatf("last %b, expected %b",
                                            rsp_item.last, want.last));
            end
         end
         if (start && !busy) begin
            n_items++;
            predict_ring_op(req_item);
         end
         took_item <= start && !busy;
      end
   end

   task automatic queue_item(input logic [1:0] mode, input int unsigned key,
                             input logic [REC_PORT_W-1:0] rec, input int unsigned cnt);
      pkrh_req_type it;
      it.mode      = mode;
      it.key_index = REQ_KEY_W'(key);
      it.record_in = rec;
      it.max_count = WANT_W'(cnt);
      req_backlog.push_back(it);
   endtask

   function automatic logic [REC_PORT_W-1:0] rand_record();
      return {$urandom(), $urandom()};
   endfunction

   // hold the sender until everything sent is taken and every record is back
   task automatic wait_drained();
      while (req_backlog.size() != 0 || start) @(posedge clock);
      while (due_records.size() != 0) @(posedge clock);
   endtask

   // one random phase: fill a ring past wrap, then a mix centered on a few keys
   task automatic queue_random_phase(input int count);
      int unsigned hot [3];
      int unsigned r;
      int unsigned cnt;
      logic [1:0]  mode;
      for (int i = 0; i < 3; i++) hot[i] = $urandom_range(KEYS - 1);
      for (int i = 0; i < DEPTH + 6; i++)
         queue_item(MODE_APPEND, hot[0], rand_record(), 0);
      queue_item(MODE_READ, hot[0], '0, DEPTH);
      queue_item(MODE_READ, hot[0], '0, 127);
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(199);
         cnt = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, 8);
         if (r < 110) begin
            queue_item(MODE_APPEND, hot[$urandom_range(2)], rand_record(),
                       $urandom_range(127));
         end else if (r < 160) begin
            queue_item(MODE_READ, hot[$urandom_range(2)], rand_record(), cnt);
         end else if (r < 163) begin
            queue_item(MODE_CLEAR, $urandom_range(4095), rand_record(), cnt);
         end else if (r < 170) begin
            queue_item(MODE_UNUSED, $urandom_range(4095), rand_record(), cnt);
         end else if (r < 184) begin
            // keys past the last ring
            mode = ($urandom_range(1) == 0) ? MODE_APPEND : MODE_READ;
            queue_item(mode, $urandom_range(KEYS, 4095), rand_record(), cnt);
         end else begin
            // anywhere in range, plus fully random noise now and then
            mode = ($urandom_range(1) == 0) ? MODE_APPEND : MODE_READ;
            if (r < 196)
               queue_item(mode, $urandom_range(KEYS - 1), rand_record(), cnt);
            else
               queue_item(2'($urandom), $urandom_range(4095), rand_record(),
                          $urandom_range(127));
         end
      end
   endtask

   initial begin
      for (int i = 0; i < KEYS; i++) begin
         ring_head[i] = '0;
         ring_fill[i] = '0;
      end
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed: empty rings, limits of max_count, ignored keys and modes, clear
      send_idle_pct = 0;
      queue_item(MODE_READ,   0,    '0, 5);
      queue_item(MODE_APPEND, 0,    {REC_PORT_W{1'b1}}, 0);
      queue_item(MODE_APPEND, 0,    '0, 127);
      queue_item(MODE_APPEND, 0,    64'ha5a5_5a5a_0f0f_f0f0, 0);
      queue_item(MODE_READ,   0,    '0, 0);
      queue_item(MODE_READ,   0,    '0, 1);
      queue_item(MODE_READ,   0,    '0, 127);
      queue_item(MODE_READ,   0,    '0, DEPTH);
      queue_item(MODE_APPEND, 4095, rand_record(), 0);
      queue_item(MODE_APPEND, KEYS, rand_record(), 0);
      queue_item(MODE_READ,   KEYS, '0, 10);
      queue_item(MODE_READ,   4095, {REC_PORT_W{1'b1}}, 127);
      queue_item(MODE_UNUSED, 0,    rand_record(), 3);
      queue_item(MODE_READ,   0,    '0, 2);
      queue_item(MODE_APPEND, KEYS - 1, 64'h8000_0000_0000_0001, 0);
      queue_item(MODE_READ,   KEYS - 1, '0, DEPTH);
      queue_item(MODE_CLEAR,  0,    '0, 0);
      queue_item(MODE_READ,   0,    '0, DEPTH);
      queue_item(MODE_READ,   KEYS - 1, '0, 1);
      queue_item(MODE_APPEND, 0,    rand_record(), 0);
      queue_item(MODE_READ,   0,    '0, DEPTH);
      wait_drained();

      // random phases with different sender gaps
      send_idle_pct = 0;
      queue_random_phase(30);
      wait_drained();
      send_idle_pct = 87;
      queue_random_phase(30);
      wait_drained();
      send_idle_pct = 33;
      queue_random_phase(30);
      wait_drained();
      send_idle_pct = 0;
      queue_random_phase(20);
      wait_drained();

      // let any trailing append or clear finish
      repeat (200) @(posedge clock);
      $display("Covered %0d items: %0d appends, %0d reads, %0d clears, rest ignored",
               n_items, n_appends, n_reads, n_clears);
      $display("Checked %0d result records across four sender gap settings", n_records);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("Timeout waiting for the block");
      $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire

// File: per_key_recent_history_ring.f
hdl/pkrh_pkg.sv
hdl/pkrh_front.sv
hdl/pkrh_queue.sv
hdl/pkrh_back.sv
hdl/per_key_recent_history_ring.sv
sim/testbench.sv
